// ===== design/dts_pkg.sv =====
// Shared types and constants for the Datalog token scanner.
package dts_pkg;

	localparam int KIND_W = 4;
	localparam int LINE_BITS = 16;
	localparam int LEN_BITS = 8;
	localparam int LINE_OUT_W = LINE_BITS;
	localparam int LEN_OUT_W = LEN_BITS;

	// Result queue depth; the scanner holds back input while fewer than two slots stay free.
	localparam int Q_DEPTH = 8;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		K_COMMA     = 4'd0,
		K_PERIOD    = 4'd1,
		K_QMARK     = 4'd2,
		K_LPAREN    = 4'd3,
		K_RPAREN    = 4'd4,
		K_COLON     = 4'd5,
		K_COLONDASH = 4'd6,
		K_SCHEMES   = 4'd7,
		K_FACTS     = 4'd8,
		K_RULES     = 4'd9,
		K_QUERIES   = 4'd10,
		K_ID        = 4'd11,
		K_STRING    = 4'd12,
		K_EOF       = 4'd13
	} kind_t;

	// An error word carries the comma code.
	localparam kind_t K_ERR_KIND = K_COMMA;

	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_PERIOD  = 8'h2E;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_QUOTE   = 8'h27;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_VTAB    = 8'h0B;
	localparam logic [7:0] CH_FFEED   = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;

	// Keyword spellings, in keyword code order.
	localparam logic [7:0] KW_TEXT [4][8] = '{
		'{"S", "c", "h", "e", "m", "e", "s", 8'h00},
		'{"F", "a", "c", "t", "s", 8'h00, 8'h00, 8'h00},
		'{"R", "u", "l", "e", "s", 8'h00, 8'h00, 8'h00},
		'{"Q", "u", "e", "r", "i", "e", "s", 8'h00}
	};
	localparam logic [3:0] KW_LEN [4] = '{4'd7, 4'd5, 4'd5, 4'd7};

	typedef struct packed {
		kind_t                 kind;
		logic [LINE_OUT_W-1:0] line;
		logic [LEN_OUT_W-1:0]  len;
		logic                  err;
		logic                  last;
	} res_t;

	// Up to two result words produced by one source byte.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r1;
		res_t       r0;
	} push_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FFEED || b == CH_CR;
	endfunction

endpackage

// ===== design/dts_in_if.sv =====
// Source byte channel: valid/ready handshake with byte and end flag.
interface dts_in_if import dts_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;

	modport source(output valid, byte_in, end_of_input, input ready);
	modport sink(input valid, byte_in, end_of_input, output ready);
endinterface

// ===== design/dts_out_if.sv =====
// Token channel: valid/ready handshake with one token or error word.
interface dts_out_if import dts_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     token_kind;
	logic [LINE_OUT_W-1:0] line_number;
	logic [LEN_OUT_W-1:0]  token_length;
	logic                  is_error;
	logic                  last_result;

	modport source(output valid, token_kind, line_number, token_length, is_error,
		last_result, input ready);
	modport sink(input valid, token_kind, line_number, token_length, is_error,
		last_result, output ready);
endinterface

// ===== design/dts_step.sv =====
// Scanner state machine: registers one byte and turns it into up to two token words.
module dts_step import dts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] byte_in,
	input  logic       end_of_input,
	output logic       busy,
	output push_t      push
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_COLON,
		M_STRING,
		M_COMMENT,
		M_DONE,
		M_HALT
	} mode_t;

	mode_t               mode_q, mode_d;
	logic [LINE_BITS-1:0] line_q, line_d, line_inc;
	logic [LEN_BITS-1:0]  run_q, run_d, run_inc;
	logic [3:0]           cand_q, cand_d;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	logic [1:0] cnt;
	res_t       r [2];
	logic       do_idle;
	kind_t      id_kind;

	function automatic logic [3:0] feed_mask(input logic [LEN_BITS-1:0] run,
		input logic [7:0] b);
		logic [3:0] m;
		for (int k = 0; k < 4; k++) begin
			m[k] = (run < LEN_BITS'(KW_LEN[k])) && (KW_TEXT[k][run[2:0]] == b);
		end
		return m;
	endfunction

	function automatic res_t mk(input kind_t kind, input logic [LEN_OUT_W-1:0] len,
		input logic err, input logic [LINE_BITS-1:0] line);
		res_t x;
		x.kind = kind;
		x.line = LINE_OUT_W'(line);
		x.len = len;
		x.err = err;
		x.last = 1'b0;
		return x;
	endfunction

	assign run_inc = (run_q == '1) ? run_q : run_q + 1'b1;
	assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;

	// First still-possible keyword whose full length has been seen.
	always_comb begin
		id_kind = K_ID;
		if (cand_q[0] && run_q == LEN_BITS'(KW_LEN[0])) begin
			id_kind = K_SCHEMES;
		end else if (cand_q[1] && run_q == LEN_BITS'(KW_LEN[1])) begin
			id_kind = K_FACTS;
		end else if (cand_q[2] && run_q == LEN_BITS'(KW_LEN[2])) begin
			id_kind = K_RULES;
		end else if (cand_q[3] && run_q == LEN_BITS'(KW_LEN[3])) begin
			id_kind = K_QUERIES;
		end
	end

	always_comb begin
		mode_d = mode_q;
		line_d = line_q;
		run_d = run_q;
		cand_d = cand_q;
		cnt = 2'd0;
		do_idle = 1'b0;
		r[0] = mk(K_EOF, '0, 1'b0, line_q);
		r[1] = mk(K_EOF, '0, 1'b0, line_q);
		if (valid_s1 && mode_q != M_DONE && mode_q != M_HALT) begin
			if (eoi_s1) begin
				unique case (mode_q)
					M_IDENT: begin
						r[cnt[0]] = mk(id_kind, LEN_OUT_W'(run_q), 1'b0, line_q);
						cnt = cnt + 2'd1;
					end
					M_COLON: begin
						r[cnt[0]] = mk(K_COLON, LEN_OUT_W'(1), 1'b0, line_q);
						cnt = cnt + 2'd1;
					end
					M_STRING: begin
						r[cnt[0]] = mk(K_ERR_KIND, '0, 1'b1, line_q);
						cnt = cnt + 2'd1;
						mode_d = M_HALT;
					end
					default: ;
				endcase
				if (mode_q != M_STRING) begin
					r[cnt[0]] = mk(K_EOF, '0, 1'b0, line_q);
					cnt = cnt + 2'd1;
					mode_d = M_DONE;
				end
			end else begin
				unique case (mode_q)
					M_IDENT: begin
						if (is_alpha(byte_s1) || is_digit(byte_s1)) begin
							cand_d = cand_q & feed_mask(run_q, byte_s1);
							run_d = run_inc;
						end else begin
							r[cnt[0]] = mk(id_kind, LEN_OUT_W'(run_q), 1'b0, line_q);
							cnt = cnt + 2'd1;
							mode_d = M_IDLE;
							do_idle = 1'b1;
						end
					end
					M_COLON: begin
						if (byte_s1 == CH_DASH) begin
							r[cnt[0]] = mk(K_COLONDASH, LEN_OUT_W'(2), 1'b0, line_q);
							cnt = cnt + 2'd1;
							mode_d = M_IDLE;
						end else begin
							r[cnt[0]] = mk(K_COLON, LEN_OUT_W'(1), 1'b0, line_q);
							cnt = cnt + 2'd1;
							mode_d = M_IDLE;
							do_idle = 1'b1;
						end
					end
					M_STRING: begin
						if (byte_s1 == CH_QUOTE) begin
							r[cnt[0]] = mk(K_STRING, LEN_OUT_W'(run_inc), 1'b0, line_q);
							cnt = cnt + 2'd1;
							run_d = run_inc;
							mode_d = M_IDLE;
						end else if (byte_s1 == CH_NEWLINE) begin
							r[cnt[0]] = mk(K_ERR_KIND, '0, 1'b1, line_q);
							cnt = cnt + 2'd1;
							mode_d = M_HALT;
						end else begin
							run_d = run_inc;
						end
					end
					M_COMMENT: begin
						if (byte_s1 == CH_NEWLINE) begin
							mode_d = M_IDLE;
							line_d = line_inc;
						end
					end
					default: begin
						mode_d = M_IDLE;
						do_idle = 1'b1;
					end
				endcase
				if (do_idle) begin
					case (byte_s1)
						CH_COMMA: begin
							r[cnt[0]] = mk(K_COMMA, LEN_OUT_W'(1), 1'b0, line_q);
							cnt = cnt + 2'd1;
						end
						CH_PERIOD: begin
							r[cnt[0]] = mk(K_PERIOD, LEN_OUT_W'(1), 1'b0, line_q);
							cnt = cnt + 2'd1;
						end
						CH_QMARK: begin
							r[cnt[0]] = mk(K_QMARK, LEN_OUT_W'(1), 1'b0, line_q);
							cnt = cnt + 2'd1;
						end
						CH_LPAREN: begin
							r[cnt[0]] = mk(K_LPAREN, LEN_OUT_W'(1), 1'b0, line_q);
							cnt = cnt + 2'd1;
						end
						CH_RPAREN: begin
							r[cnt[0]] = mk(K_RPAREN, LEN_OUT_W'(1), 1'b0, line_q);
							cnt = cnt + 2'd1;
						end
						CH_COLON: mode_d = M_COLON;
						CH_QUOTE: begin
							mode_d = M_STRING;
							run_d = LEN_BITS'(1);
						end
						CH_NEWLINE: line_d = line_inc;
						CH_HASH: mode_d = M_COMMENT;
						default: begin
							if (is_alpha(byte_s1)) begin
								mode_d = M_IDENT;
								run_d = LEN_BITS'(1);
								cand_d = feed_mask('0, byte_s1);
							end else if (!is_blank(byte_s1)) begin
								r[cnt[0]] = mk(K_ERR_KIND, '0, 1'b1, line_q);
								cnt = cnt + 2'd1;
								mode_d = M_HALT;
							end
						end
					endcase
				end
			end
		end
		// Mark the final word of this byte.
		if (cnt == 2'd2) begin
			r[1].last = 1'b1;
		end else if (cnt == 2'd1) begin
			r[0].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= M_IDLE;
			line_q <= LINE_BITS'(1);
			run_q <= '0;
			cand_q <= 4'hF;
		end else begin
			valid_s1 <= fire;
			mode_q <= mode_d;
			line_q <= line_d;
			run_q <= run_d;
			cand_q <= cand_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_s1 <= byte_in;
			eoi_s1 <= end_of_input;
		end
	end

	assign busy = valid_s1;
	assign push.cnt = cnt;
	assign push.r0 = r[0];
	assign push.r1 = r[1];

endmodule

// ===== design/dts_fifo.sv =====
// Result queue: takes up to two words per cycle, hands out one.
module dts_fifo import dts_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  push_t           push,
	input  logic            pop,
	output logic            head_valid,
	output res_t            head,
	output logic [Q_CW-1:0] count
);

	res_t            q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_CW-1:0] cnt_q;
	logic [Q_AW-1:0] wp_next;

	assign wp_next = wp_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			q_mem[wp_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			q_mem[wp_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + Q_AW'(push.cnt);
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + Q_CW'(push.cnt) - Q_CW'(pop);
		end
	end

	assign head_valid = cnt_q != '0;
	assign head = q_mem[rp_q];
	assign count = cnt_q;

endmodule

// ===== design/datalog_token_scanner_unit.sv =====
// Datalog token scanner top level: byte channel in, token channel out.
//
// byte_ch takes one source byte per word; end_of_input marks the end of the
// text and byte_in is then ignored. token_ch gives one token per word with
// kind, line and length; is_error marks a scan error and last_result flags
// the final word caused by one source byte. An eof token closes the stream;
// after it, or after an error, bytes are still taken but give nothing.
//
// Throughput: one byte per cycle while the receiver keeps up. A byte that
// ends a pending token gives two words, which the token channel hands out
// one at a time. A word reaches token_ch after passing through the input
// register and then the result queue.
// The eight-word result queue sets the stall point: byte_ch.ready drops
// once fewer than two free slots remain after the byte in flight, so a
// stalled receiver halts input without losing words.
// Reset returns to line one with no token pending and empties the queue.
module datalog_token_scanner_unit import dts_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	dts_in_if.sink   byte_ch,
	dts_out_if.source token_ch
);

	logic            fire;
	logic            busy;
	push_t           push;
	logic            pop;
	res_t            head;
	logic [Q_CW-1:0] count;

	// Hold input unless the queue can take two words beyond the byte in flight.
	assign byte_ch.ready = (count + (busy ? Q_CW'(2) : Q_CW'(0))) <= Q_CW'(Q_DEPTH - 2);
	assign fire = byte_ch.valid && byte_ch.ready;

	dts_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.byte_in(byte_ch.byte_in),
		.end_of_input(byte_ch.end_of_input),
		.busy(busy),
		.push(push)
	);

	assign pop = token_ch.valid && token_ch.ready;

	dts_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.head_valid(token_ch.valid),
		.head(head),
		.count(count)
	);

	assign token_ch.token_kind = head.kind;
	assign token_ch.line_number = head.line;
	assign token_ch.token_length = head.len;
	assign token_ch.is_error = head.err;
	assign token_ch.last_result = head.last;

endmodule

// ===== tb/sv/datalog_token_scanner_unit_tb.sv =====
// Self-checking testbench for the Datalog token scanner: byte stream in, predicted token words out.
`timescale 1ns / 100ps

module datalog_token_scanner_unit_tb;
	import dts_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} src_item_t;

	typedef enum logic [2:0] {
		SC_IDLE, SC_IDENT, SC_COLON, SC_STRING, SC_COMMENT, SC_DONE, SC_HALT
	} scan_st_t;

	localparam int IDLE_PCT = 17;
	localparam int RANDOM_ITEMS = 1200;

	logic clk = 1'b0;
	logic arst_n;

	dts_in_if byte_ch ();
	dts_out_if token_ch ();

	datalog_token_scanner_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.token_ch(token_ch)
	);

	src_item_t src_bytes[$];
	src_item_t cur_item;
	res_t tokens_due[$];
	res_t seen_w, due_w;
	bit offering = 1'b0;
	bit stall = 1'b0;
	int cyc = 0;
	int n_taken = 0;
	int n_words = 0;
	int n_mismatch = 0;

	// scanner state as predicted
	scan_st_t sc_st;
	logic [15:0] sc_line;
	logic [7:0] sc_run;
	logic [3:0] sc_live;

	wire calm = cyc >= 1000 && cyc < 1500;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic string kw_name(int k);
		case (k)
		0: return "Schemes";
		1: return "Facts";
		2: return "Rules";
		default: return "Queries";
		endcase
	endfunction

	function automatic bit letter(logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic bit numeral(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic bit spacing(logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FFEED || b == CH_CR;
	endfunction

	task automatic emit_word(kind_t k, logic [7:0] len, bit err);
		res_t w;
		w.kind = k;
		w.line = sc_line;
		w.len = len;
		w.err = err;
		w.last = 1'b0;
		tokens_due.insert(tokens_due.size(), w);
	endtask

	task automatic bump_line();
		if (sc_line != 16'hFFFF)
			sc_line++;
	endtask

	task automatic bump_run();
		if (sc_run != 8'hFF)
			sc_run++;
	endtask

	task automatic feed_letter(logic [7:0] b);
		string s;
		for (int k = 0; k < 4; k++) begin
			s = kw_name(k);
			if (sc_run >= s.len() || s[sc_run] != b)
				sc_live[k] = 1'b0;
		end
		bump_run();
	endtask

	task automatic close_ident();
		kind_t k;
		string s;
		k = K_ID;
		// walk down so the lowest matching keyword code wins
		for (int i = 3; i >= 0; i--) begin
			s = kw_name(i);
			if (sc_live[i] && sc_run == s.len())
				k = kind_t'(int'(K_SCHEMES) + i);
		end
		emit_word(k, sc_run, 1'b0);
		sc_st = SC_IDLE;
	endtask

	task automatic raise_fault();
		emit_word(K_ERR_KIND, 8'd0, 1'b1);
		sc_st = SC_HALT;
	endtask

	task automatic idle_char(logic [7:0] b);
		case (b)
		CH_COMMA: emit_word(K_COMMA, 8'd1, 1'b0);
		CH_PERIOD: emit_word(K_PERIOD, 8'd1, 1'b0);
		CH_QMARK: emit_word(K_QMARK, 8'd1, 1'b0);
		CH_LPAREN: emit_word(K_LPAREN, 8'd1, 1'b0);
		CH_RPAREN: emit_word(K_RPAREN, 8'd1, 1'b0);
		CH_COLON: sc_st = SC_COLON;
		CH_QUOTE: begin
			sc_st = SC_STRING;
			sc_run = 8'd1;
		end
		CH_NEWLINE: bump_line();
		CH_HASH: sc_st = SC_COMMENT;
		default: begin
			if (letter(b)) begin
				sc_st = SC_IDENT;
				sc_run = 8'd0;
				sc_live = 4'hF;
				feed_letter(b);
			end else if (!spacing(b)) begin
				raise_fault();
			end
		end
		endcase
	endtask

	task automatic scan_byte(src_item_t it);
		int n_before;
		n_before = tokens_due.size();
		// silent once eof or an error has gone out
		if (sc_st == SC_DONE || sc_st == SC_HALT)
			return;
		if (it.eoi) begin
			case (sc_st)
			SC_IDENT: close_ident();
			SC_COLON: emit_word(K_COLON, 8'd1, 1'b0);
			SC_STRING: raise_fault();
			default: ;
			endcase
			if (sc_st != SC_HALT) begin
				emit_word(K_EOF, 8'd0, 1'b0);
				sc_st = SC_DONE;
			end
		end else begin
			case (sc_st)
			SC_IDENT: begin
				if (letter(it.b) || numeral(it.b)) begin
					feed_letter(it.b);
				end else begin
					close_ident();
					idle_char(it.b);
				end
			end
			SC_COLON: begin
				if (it.b == CH_DASH) begin
					emit_word(K_COLONDASH, 8'd2, 1'b0);
					sc_st = SC_IDLE;
				end else begin
					emit_word(K_COLON, 8'd1, 1'b0);
					sc_st = SC_IDLE;
					idle_char(it.b);
				end
			end
			SC_STRING: begin
				if (it.b == CH_QUOTE) begin
					bump_run();
					emit_word(K_STRING, sc_run, 1'b0);
					sc_st = SC_IDLE;
				end else if (it.b == CH_NEWLINE) begin
					raise_fault();
				end else begin
					bump_run();
				end
			end
			SC_COMMENT: begin
				if (it.b == CH_NEWLINE) begin
					sc_st = SC_IDLE;
					bump_line();
				end
			end
			default: idle_char(it.b);
			endcase
		end
		if (tokens_due.size() > n_before)
			tokens_due[tokens_due.size() - 1].last = 1'b1;
	endtask

	task automatic put_item(logic [7:0] b, logic eoi);
		src_bytes.insert(src_bytes.size(), src_item_t'{b, eoi});
	endtask

	task automatic put_byte(logic [7:0] b);
		put_item(b, 1'b0);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'(8'h61 + $urandom_range(0, 25));
		return 8'(8'h41 + $urandom_range(0, 25));
	endfunction

	task automatic put_ident(int n);
		put_byte(rand_letter());
		repeat (n - 1) begin
			if ($urandom_range(0, 3) == 0)
				put_byte(8'(8'h30 + $urandom_range(0, 9)));
			else
				put_byte(rand_letter());
		end
	endtask

	task automatic put_string(int n);
		logic [7:0] b;
		put_byte(CH_QUOTE);
		repeat (n) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == CH_QUOTE || b == CH_NEWLINE);
			put_byte(b);
		end
		put_byte(CH_QUOTE);
	endtask

	// One well-formed piece of source; none opens with a digit or leaves a string open.
	task automatic add_piece();
		string s;
		logic [7:0] b;
		case ($urandom_range(0, 15))
		0: put_byte(CH_COMMA);
		1: put_byte(CH_PERIOD);
		2: put_byte(CH_QMARK);
		3: put_byte(CH_LPAREN);
		4: put_byte(CH_RPAREN);
		5: put_byte(CH_COLON);
		6: put_text(":-");
		7, 8: put_text(kw_name($urandom_range(0, 3)));
		9: begin
			// near miss of a keyword
			s = kw_name($urandom_range(0, 3));
			case ($urandom_range(0, 2))
			0: s = s.substr(0, s.len() - 2);
			1: s = {s, "s"};
			default: s[0] = s[0] + 8'h20;
			endcase
			put_text(s);
		end
		10, 11: put_ident($urandom_range(1, 10));
		12: put_string($urandom_range(0, 8));
		13: begin
			put_byte(CH_HASH);
			repeat ($urandom_range(0, 6)) begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_NEWLINE);
				put_byte(b);
			end
			put_byte(CH_NEWLINE);
		end
		default: begin
			case ($urandom_range(0, 5))
			0: put_byte(CH_SPACE);
			1: put_byte(CH_TAB);
			2: put_byte(CH_VTAB);
			3: put_byte(CH_FFEED);
			4: put_byte(CH_CR);
			default: put_byte(CH_NEWLINE);
			endcase
		end
		endcase
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("word %0d: %s got %0d, expected %0d", n_words, what, got, want);
		n_mismatch++;
	endtask

	// Driver: offer at the falling edge, hold a word until it is taken.
	always @(negedge clk) begin
		if (arst_n && !offering) begin
			if (src_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				cur_item = src_bytes.pop_front();
				offering = 1'b1;
				byte_ch.valid <= 1'b1;
				byte_ch.byte_in <= cur_item.b;
				byte_ch.end_of_input <= cur_item.eoi;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		token_ch.ready <= !stall && (calm || $urandom_range(0, 99) >= IDLE_PCT);

	// Monitor: predict on each byte taken, then check each token word taken.
	always @(posedge clk) begin
		cyc++;
		if (byte_ch.valid && byte_ch.ready) begin
			scan_byte(cur_item);
			offering = 1'b0;
			n_taken++;
		end
		if (token_ch.valid && token_ch.ready) begin
			seen_w.kind = kind_t'(token_ch.token_kind);
			seen_w.line = token_ch.line_number;
			seen_w.len = token_ch.token_length;
			seen_w.err = token_ch.is_error;
			seen_w.last = token_ch.last_result;
			if (tokens_due.size() == 0) begin
				report_mismatch("unexpected word, kind", seen_w.kind, -1);
			end else begin
				due_w = tokens_due.pop_front();
				if (seen_w.kind !== due_w.kind)
					report_mismatch("token_kind", seen_w.kind, due_w.kind);
				if (seen_w.line !== due_w.line)
					report_mismatch("line_number", seen_w.line, due_w.line);
				if (seen_w.len !== due_w.len)
					report_mismatch("token_length", seen_w.len, due_w.len);
				if (seen_w.err !== due_w.err)
					report_mismatch("is_error", seen_w.err, due_w.err);
				if (seen_w.last !== due_w.last)
					report_mismatch("last_result", seen_w.last, due_w.last);
			end
			n_words++;
		end
	end

	// Hold off the receiver so the result queue fills and the input stalls.
	initial begin
		while (n_taken < 400)
			@(posedge clk);
		stall = 1'b1;
		repeat (150) @(posedge clk);
		stall = 1'b0;
	end

	initial begin
		#5000000;
		$display("datalog_token_scanner_unit test failed");
		$finish;
	end

	initial begin
		int base;
		int t;
		logic [7:0] b;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.byte_in = 8'd0;
		byte_ch.end_of_input = 1'b0;
		token_ch.ready = 1'b0;
		sc_st = SC_IDLE;
		sc_line = 16'd1;
		sc_run = 8'd0;
		sc_live = 4'hF;

		// every punctuation, colon against colon-dash, a string, a comment, a keyword, blanks
		put_text(",.?():-:'a'#");
		put_byte(8'h01);
		put_byte(CH_NEWLINE);
		put_text("Rules");
		put_byte(CH_TAB);
		put_byte(CH_VTAB);
		put_byte(CH_FFEED);
		put_byte(CH_CR);
		// saturate token length in both an identifier and a string
		put_ident(300);
		put_byte(CH_SPACE);
		put_string(300);

		base = src_bytes.size();
		while (src_bytes.size() < base + RANDOM_ITEMS)
			add_piece();

		repeat (6) add_piece();

		// close the text one way; only one ending is possible per reset
		t = $urandom_range(0, 8);
		case (t)
		0: ;
		1: put_text("#x");
		2: put_ident($urandom_range(1, 8));
		3: put_byte(CH_COLON);
		4: put_text("'ab");
		5: begin
			put_text("'ab");
			put_byte(CH_NEWLINE);
		end
		6: begin
			put_byte(CH_SPACE);
			put_byte(8'(8'h30 + $urandom_range(0, 9)));
		end
		7: begin
			if ($urandom_range(0, 1))
				put_ident(3);
			else
				put_byte(CH_COLON);
		end
		default: put_byte(CH_SPACE);
		endcase
		if (t >= 7) begin
			do
				b = 8'($urandom_range(0, 255));
			while (letter(b) || numeral(b) || spacing(b) || b == CH_COMMA
				|| b == CH_PERIOD || b == CH_QMARK || b == CH_LPAREN
				|| b == CH_RPAREN || b == CH_COLON || b == CH_QUOTE
				|| b == CH_HASH || b == CH_NEWLINE);
			put_byte(b);
		end
		put_item(8'($urandom_range(0, 255)), 1'b1);
		// anything after the end is dropped
		repeat (20)
			put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (src_bytes.size() != 0 || offering)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_mismatch == 0)
			$display("datalog_token_scanner_unit test passed");
		else
			$display("datalog_token_scanner_unit test failed");
		$finish;
	end

endmodule
